>>> rtl/tla_pkg.sv
// shared types and constants for the toroidal life automaton
package tla_pkg;

	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_ROWS    = 64;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0]     DIM_RESET       = 7'd20;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [1:0] {
		OP_STEP   = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR_RST,
		ST_CLR_OP,
		ST_TGL_RD,
		ST_TGL_WT,
		ST_LD0,
		ST_LD1,
		ST_LD2,
		ST_LD3,
		ST_CELL,
		ST_WR,
		ST_RDN,
		ST_FIN_RD,
		ST_FIN_WT
	} state_t;

endpackage

>>> rtl/tla_ram.sv
// generic single-write, single-read ram with registered read data
module tla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tla_rule_unit.sv
// shared per-cell unit: wrapped neighbour count and life rule for one column
module tla_rule_unit #(
	parameter int MAX_COLUMNS = tla_pkg::DEF_MAX_COLUMNS
) (
	input  logic [MAX_COLUMNS-1:0]                                  prev_row,
	input  logic [MAX_COLUMNS-1:0]                                  cur_row,
	input  logic [MAX_COLUMNS-1:0]                                  nxt_row,
	input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] col,
	input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] col_last,
	output logic                                                    next_bit
);
	import tla_pkg::*;

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	logic [CW-1:0] col_m;
	logic [CW-1:0] col_p;
	logic [3:0]    count;
	logic          alive;

	always_comb begin
		// toroidal wrap on the in-use columns
		col_m = (col == '0) ? col_last : CW'(col - CW'(1));
		col_p = (col == col_last) ? '0 : CW'(col + CW'(1));
		count = 4'(prev_row[col_m]) + 4'(prev_row[col]) + 4'(prev_row[col_p])
		      + 4'(cur_row[col_m]) + 4'(cur_row[col_p])
		      + 4'(nxt_row[col_m]) + 4'(nxt_row[col]) + 4'(nxt_row[col_p]);
		alive = cur_row[col];
		next_bit = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
	end

endmodule

>>> rtl/toroidal_life_automaton_top.sv
// top level of the toroidal life automaton: sequencer, row buffers and grid ram
//
// Input channel (in_valid/in_ready) takes one item: func, cell_x, cell_y.
// Output channel (out_valid/out_ready) returns one item per input item:
// cell_value (addressed cell after the operation, 0 outside the in-use area)
// and generation_count. Items are handled one at a time.
// The grid lives in a ram of MAX_ROWS rows of MAX_COLUMNS bits, one port
// each for read and write; a step walks the rows and evaluates one cell per
// cycle with a single shared rule unit, keeping three old rows in registers.
// A new item is accepted while the previous result still waits at the output;
// if the receiver stalls, the next result holds in the last state until the
// output register frees up, and ready stays low until then.
// Reset clears the generation counter, sets both dimensions to 20 and runs a
// clearing pass over the ram, one row per cycle, before the first item is
// accepted. Configuration (cfg_we, cfg_index, cfg_data) takes effect at once.
// The user must write it only while the block is idle; nothing enforces it.
module toroidal_life_automaton_top #(
	parameter int MAX_COLUMNS = tla_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tla_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tla_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [5:0]                     cell_x,
	input  logic [5:0]                     cell_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           cell_value,
	output logic [31:0]                    generation_count
);
	import tla_pkg::*;

	localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNW = $clog2(MAX_COLUMNS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic [31:0]      gen_q;
	logic [31:0]      count_q;
	logic [CW-1:0]    x_q;
	logic [RW-1:0]    y_q;
	logic             out_valid_q;

	op_t              func_q;
	logic [CW-1:0]    x_idx_q;
	logic [RW-1:0]    y_idx_q;
	logic             inside_q;
	logic             cell_value_q;

	logic [MAX_COLUMNS-1:0] prev_q, cur_q, nxt_q, row0_q, new_q;

	logic [CNW-1:0] w_eff;
	logic [RNW-1:0] h_eff;
	logic [CW-1:0]  x_last;
	logic [RW-1:0]  y_last;
	logic           y_is_last;
	logic           rd_next;
	logic           accept;
	logic           out_free;
	logic           inside_in;
	logic           rule_bit;

	logic                   ram_we, ram_re;
	logic [RW-1:0]          ram_waddr, ram_raddr;
	logic [MAX_COLUMNS-1:0] ram_wdata, ram_rdata;

	// effective dimensions: zero counts as one, capped at capacity
	always_comb begin
		if (grid_width_q == '0) begin
			w_eff = CNW'(1);
		end else if (32'(grid_width_q) > MAX_COLUMNS) begin
			w_eff = CNW'(MAX_COLUMNS);
		end else begin
			w_eff = CNW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			h_eff = RNW'(1);
		end else if (32'(grid_height_q) > MAX_ROWS) begin
			h_eff = RNW'(MAX_ROWS);
		end else begin
			h_eff = RNW'(grid_height_q);
		end
		x_last    = CW'(w_eff - CNW'(1));
		y_last    = RW'(h_eff - RNW'(1));
		y_is_last = (y_q == y_last);
		rd_next   = (16'(y_q) + 16'd2) < 16'(h_eff);
		inside_in = (16'(cell_x) < 16'(w_eff)) && (16'(cell_y) < 16'(h_eff));
		accept    = in_valid && in_ready;
		out_free  = !out_valid_q || out_ready;
	end

	tla_rule_unit #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_rule (
		.prev_row(prev_q),
		.cur_row (cur_q),
		.nxt_row (nxt_q),
		.col     (x_q),
		.col_last(x_last),
		.next_bit(rule_bit)
	);

	tla_ram #(
		.WIDTH(MAX_COLUMNS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(func))
						OP_STEP:   state_d = ST_LD0;
						OP_TOGGLE: state_d = ST_TGL_RD;
						OP_CLEAR:  state_d = ST_CLR_OP;
						OP_READ:   state_d = ST_FIN_RD;
					endcase
				end
			end
			ST_CLR_RST: begin
				if (y_q == RW'(MAX_ROWS - 1)) state_d = ST_IDLE;
			end
			ST_CLR_OP: begin
				if (y_q == RW'(MAX_ROWS - 1)) state_d = ST_FIN_RD;
			end
			ST_TGL_RD: state_d = ST_TGL_WT;
			ST_TGL_WT: state_d = ST_FIN_RD;
			ST_LD0:    state_d = ST_LD1;
			ST_LD1:    state_d = ST_LD2;
			ST_LD2:    state_d = ST_LD3;
			ST_LD3:    state_d = ST_CELL;
			ST_CELL: begin
				if (x_q == x_last) state_d = ST_WR;
			end
			ST_WR: begin
				if (y_is_last) begin
					state_d = ST_FIN_RD;
				end else if (rd_next) begin
					state_d = ST_RDN;
				end else begin
					state_d = ST_CELL;
				end
			end
			ST_RDN:    state_d = ST_CELL;
			ST_FIN_RD: state_d = ST_FIN_WT;
			ST_FIN_WT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// ram control and handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = y_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = y_idx_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CLR_RST, ST_CLR_OP: begin
				ram_we = 1'b1;
			end
			ST_TGL_RD: ram_re = 1'b1;
			ST_TGL_WT: begin
				ram_we    = inside_q;
				ram_waddr = y_idx_q;
				ram_wdata = ram_rdata;
				ram_wdata[x_idx_q] = ~ram_rdata[x_idx_q];
			end
			ST_LD0: begin
				ram_re    = 1'b1;
				ram_raddr = y_last;
			end
			ST_LD1: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_LD2: begin
				// row below row zero, which is row zero itself on a one-row area
				ram_re    = 1'b1;
				ram_raddr = (h_eff == RNW'(1)) ? '0 : RW'(1);
			end
			ST_WR: begin
				ram_we    = 1'b1;
				ram_wdata = new_q;
				ram_re    = !y_is_last && rd_next;
				ram_raddr = RW'(y_q + RW'(2));
			end
			ST_FIN_RD: ram_re = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR_RST;
			grid_width_q  <= DIM_RESET;
			grid_height_q <= DIM_RESET;
			gen_q         <= '0;
			count_q       <= '0;
			x_q           <= '0;
			y_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) y_q <= '0;
				end
				ST_CLR_RST, ST_CLR_OP: begin
					if (y_q == RW'(MAX_ROWS - 1)) begin
						y_q <= '0;
						if (state_q == ST_CLR_OP) gen_q <= '0;
					end else begin
						y_q <= RW'(y_q + RW'(1));
					end
				end
				ST_LD3: x_q <= '0;
				ST_CELL: begin
					x_q <= (x_q == x_last) ? '0 : CW'(x_q + CW'(1));
				end
				ST_WR: begin
					if (y_is_last) begin
						gen_q <= gen_q + 32'd1;
						y_q   <= '0;
					end else begin
						y_q <= RW'(y_q + RW'(1));
					end
				end
				default: ;
			endcase
			// the count is captured with the item so later work cannot disturb it
			if (state_q == ST_FIN_WT && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= gen_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item fields and row buffers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= op_t'(func);
			x_idx_q  <= CW'(cell_x);
			y_idx_q  <= RW'(cell_y);
			inside_q <= inside_in;
		end
		unique case (state_q)
			ST_LD1: prev_q <= ram_rdata;
			ST_LD2: begin
				cur_q  <= ram_rdata;
				row0_q <= ram_rdata;
				new_q  <= ram_rdata;
			end
			ST_LD3: nxt_q <= ram_rdata;
			ST_CELL: new_q[x_q] <= rule_bit;
			ST_WR: begin
				if (!y_is_last) begin
					// slide the window; columns outside the area keep old bits
					prev_q <= cur_q;
					cur_q  <= nxt_q;
					new_q  <= nxt_q;
					if (!rd_next) nxt_q <= row0_q;
				end
			end
			ST_RDN: nxt_q <= ram_rdata;
			ST_FIN_WT: begin
				if (out_free) cell_value_q <= inside_q && ram_rdata[x_idx_q];
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign cell_value       = cell_value_q;
	assign generation_count = count_q;

	// a clear item always reports a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_WT && func_q == OP_CLEAR) |-> (gen_q == '0))
		else $error("count not zero after clear");

	// finishing the last row of a step bumps the count by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && y_is_last) |=> (gen_q == $past(gen_q) + 32'd1))
		else $error("step did not advance the count");

	// the column sweep stays inside the in-use columns
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> (x_q <= x_last))
		else $error("column index beyond grid width");

	// no grid write while the block is open for a new item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ram_we)
		else $error("grid written while idle");

	// a fresh result for an out-of-range coordinate reads dead
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && !inside_q) |-> !cell_value_q)
		else $error("out-of-range cell reported alive");

endmodule
